### sv/streaming_kth_largest_tracker_core_defines.svh
// Assertion macros used by the checker file of the kth-largest tracker.
`ifndef STREAMING_KTH_LARGEST_TRACKER_CORE_DEFINES_SVH
`define STREAMING_KTH_LARGEST_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KTHTRK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kthtrk: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define KTHTRK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kthtrk: next-cycle check failed");

`endif

### sv/kthtrk_pkg.sv
// Shared types and constants of the kth-largest tracker.
`timescale 1ns / 1ps
package kthtrk_pkg;

   localparam int DATA_W = 32;
   localparam int RANK_W = 5;
   localparam logic [RANK_W-1:0] RANK_RESET = 5'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_PUT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample_echo;
      logic signed [DATA_W-1:0] kth_largest;
   } result_type;

endpackage

### sv/kthtrk_store.sv
// Sorted-sample store: one write port, one registered read port.
`timescale 1ns / 1ps
module kthtrk_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [AW-1:0]                         wr_addr,
   input  logic signed [kthtrk_pkg::DATA_W-1:0]  wr_data,
   input  logic [AW-1:0]                         rd_addr,
   output logic signed [kthtrk_pkg::DATA_W-1:0]  rd_data
);

   logic signed [kthtrk_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [kthtrk_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/kthtrk_seq.sv
// Sequencer and shared compare unit that walk the sorted store one cell at a time.
`timescale 1ns / 1ps
module kthtrk_seq #(
   parameter int MAX_RANK = 16,
   parameter int AW       = 4,
   parameter int CW       = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [kthtrk_pkg::RANK_W-1:0]         csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [kthtrk_pkg::DATA_W-1:0]  req_sample,
   output logic                                  fin_valid,
   input  logic                                  fin_ready,
   output kthtrk_pkg::result_type                fin_data,
   output logic                                  mem_wr_en,
   output logic [AW-1:0]                         mem_wr_addr,
   output logic signed [kthtrk_pkg::DATA_W-1:0]  mem_wr_data,
   output logic [AW-1:0]                         mem_rd_addr,
   input  logic signed [kthtrk_pkg::DATA_W-1:0]  mem_rd_data
);

   localparam int RW = (CW > kthtrk_pkg::RANK_W) ? CW : kthtrk_pkg::RANK_W;

   kthtrk_pkg::state_type state_ff, state_in;

   logic [kthtrk_pkg::RANK_W-1:0]        rank_ff, rank_in;
   logic [CW-1:0]                        fill_ff, fill_in;
   logic [AW-1:0]                        pos_ff, pos_in;
   logic                                 add_ff, add_in;
   logic signed [kthtrk_pkg::DATA_W-1:0] smp_ff, smp_in;
   logic signed [kthtrk_pkg::DATA_W-1:0] min_ff, min_in;

   logic [RW-1:0] rank_ext;
   logic [CW-1:0] eff_rank;
   logic          has_room;
   logic          rd_above;
   logic          rd_below;
   logic          more_right;

   // Clamp the rank to 1..MAX_RANK.
   always_comb begin
      rank_ext = RW'(rank_ff);
      if (rank_ff == '0) begin
         eff_rank = CW'(1);
      end else if (rank_ext > RW'(MAX_RANK)) begin
         eff_rank = CW'(MAX_RANK);
      end else begin
         eff_rank = rank_ext[CW-1:0];
      end
   end

   assign has_room   = (fill_ff < eff_rank);
   assign rd_above   = (mem_rd_data > smp_ff);
   assign rd_below   = (mem_rd_data < smp_ff);
   assign more_right = ((CW+1)'(pos_ff) + (CW+1)'(2)) < (CW+1)'(fill_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kthtrk_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (has_room) begin
                  state_in = (fill_ff == '0) ? kthtrk_pkg::ST_PUT : kthtrk_pkg::ST_READ;
               end else if (req_sample > min_ff) begin
                  state_in = (fill_ff == CW'(1)) ? kthtrk_pkg::ST_PUT : kthtrk_pkg::ST_READ;
               end else begin
                  state_in = kthtrk_pkg::ST_FIN;
               end
            end
         end
         kthtrk_pkg::ST_READ: begin
            state_in = kthtrk_pkg::ST_CMP;
         end
         kthtrk_pkg::ST_CMP: begin
            if (add_ff) begin
               state_in = (rd_above && pos_ff != AW'(1)) ? kthtrk_pkg::ST_READ
                                                          : kthtrk_pkg::ST_PUT;
            end else begin
               state_in = (rd_below && more_right) ? kthtrk_pkg::ST_READ
                                                   : kthtrk_pkg::ST_PUT;
            end
         end
         kthtrk_pkg::ST_PUT: begin
            state_in = kthtrk_pkg::ST_FIN;
         end
         kthtrk_pkg::ST_FIN: begin
            if (fin_ready) begin
               state_in = kthtrk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kthtrk_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      rank_in     = rank_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      add_in      = add_ff;
      smp_in      = smp_ff;
      min_in      = min_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = pos_ff;
      mem_wr_data = smp_ff;
      mem_rd_addr = add_ff ? (pos_ff - AW'(1)) : (pos_ff + AW'(1));
      req_ready   = (state_ff == kthtrk_pkg::ST_IDLE);
      fin_valid   = (state_ff == kthtrk_pkg::ST_FIN);
      fin_data.sample_echo = smp_ff;
      fin_data.kth_largest = min_ff;
      case (state_ff)
         kthtrk_pkg::ST_IDLE: begin
            if (req_valid) begin
               smp_in = req_sample;
               add_in = has_room;
               pos_in = has_room ? fill_ff[AW-1:0] : '0;
            end
         end
         kthtrk_pkg::ST_CMP: begin
            // Shift the visited cell one place toward the hole.
            if (add_ff && rd_above) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = mem_rd_data;
               pos_in      = pos_ff - AW'(1);
            end else if (!add_ff && rd_below) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = mem_rd_data;
               pos_in      = pos_ff + AW'(1);
               if (pos_ff == '0) begin
                  min_in = mem_rd_data;
               end
            end
         end
         kthtrk_pkg::ST_PUT: begin
            mem_wr_en = 1'b1;
            if (pos_ff == '0) begin
               min_in = smp_ff;
            end
            if (add_ff) begin
               fill_in = fill_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
      // A rank write empties the store.
      if (csr_wr_en) begin
         rank_in = csr_wr_data;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kthtrk_pkg::ST_IDLE;
         rank_ff  <= kthtrk_pkg::RANK_RESET;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rank_ff  <= rank_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      add_ff <= add_in;
      smp_ff <= smp_in;
      min_ff <= min_in;
   end

endmodule

### sv/streaming_kth_largest_tracker_core.sv
// Top level of the streaming kth-largest tracker.
// A dropped sample goes from IDLE straight to FIN; a placed sample passes READ and CMP once
// for each cell it is compared with, then PUT and FIN. The result then loads into the output register.
// One item at a time: a new sample is taken only back in IDLE; each visited cell costs a
// read and a compare on the store's one read port. A finished beat waits in the output register.
// Reset (synchronous, active high): empty store, rank_k = 3, no beat pending.
`timescale 1ns / 1ps
module streaming_kth_largest_tracker_core #(
   parameter int MAX_RANK = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [kthtrk_pkg::RANK_W-1:0]         csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [kthtrk_pkg::DATA_W-1:0]  req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [kthtrk_pkg::DATA_W-1:0]  rsp_sample_echo,
   output logic signed [kthtrk_pkg::DATA_W-1:0]  rsp_kth_largest
);

   localparam int AW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int CW = $clog2(MAX_RANK + 1);

   logic                                 fin_valid;
   logic                                 fin_ready;
   kthtrk_pkg::result_type               fin_data;
   logic                                 mem_wr_en;
   logic [AW-1:0]                        mem_wr_addr;
   logic signed [kthtrk_pkg::DATA_W-1:0] mem_wr_data;
   logic [AW-1:0]                        mem_rd_addr;
   logic signed [kthtrk_pkg::DATA_W-1:0] mem_rd_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   kthtrk_pkg::result_type rsp_data_ff, rsp_data_in;

   kthtrk_seq #(
      .MAX_RANK (MAX_RANK),
      .AW       (AW),
      .CW       (CW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .fin_valid   (fin_valid),
      .fin_ready   (fin_ready),
      .fin_data    (fin_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   kthtrk_store #(
      .DEPTH (MAX_RANK),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: load when empty or when the held beat leaves.
   assign fin_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fin_ready) begin
         rsp_valid_in = fin_valid;
         if (fin_valid) begin
            rsp_data_in = fin_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_echo = rsp_data_ff.sample_echo;
   assign rsp_kth_largest = rsp_data_ff.kth_largest;

endmodule

### sv/kthtrk_checker.sv
// Port-level checker for the kth-largest tracker, bound to the top level.
`timescale 1ns / 1ps
`include "streaming_kth_largest_tracker_core_defines.svh"
module kthtrk_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [kthtrk_pkg::DATA_W-1:0]  rsp_sample_echo,
   input logic signed [kthtrk_pkg::DATA_W-1:0]  rsp_kth_largest
);

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] pending_ff, pending_in;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Count accepted beats whose result has not left yet.
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_beat && rsp_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `KTHTRK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_echo) && $stable(rsp_kth_largest))
   `KTHTRK_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_beat, !req_ready)
   `KTHTRK_ASSERT_NOW(a_pending_bound, clock, reset, 1'b1, pending_ff <= 2'd2)
   `KTHTRK_ASSERT_NOW(a_one_in_flight, clock, reset, !rsp_valid, pending_ff <= 2'd1)
   `KTHTRK_ASSERT_NOW(a_no_invented_rsp, clock, reset, $rose(rsp_valid), pending_ff != 2'd0)

endmodule

bind streaming_kth_largest_tracker_core kthtrk_checker u_kthtrk_checker (.*);

### tb/tb_streaming_kth_largest_tracker_core.sv
// Self-checking testbench of the streaming kth-largest tracker, with an inline rank predictor.
`timescale 1ns / 1ps
module tb_streaming_kth_largest_tracker_core;

   localparam int DW = kthtrk_pkg::DATA_W;
   localparam int RW = kthtrk_pkg::RANK_W;
   localparam int STORE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 94;
   localparam int DRAIN_CYCLES = 2 * STORE_DEPTH + 8;
   localparam logic signed [DW-1:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [DW-1:0] S_MAX = 32'sh7FFF_FFFF;

   typedef enum logic {ROW_RANK, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic signed [DW-1:0] value;
      bit                   typed;
      logic signed [DW-1:0] kth;
   } dir_row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [RW-1:0]        csr_wr_data;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [DW-1:0] req_sample;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [DW-1:0] rsp_sample_echo;
   logic signed [DW-1:0] rsp_kth_largest;

   // Predictor state: ascending chain of kept samples, minimum in cell 0.
   logic signed [DW-1:0] kept_chain [STORE_DEPTH];
   int                   kept_count;
   logic [RW-1:0]        rank_reg;

   kthtrk_pkg::result_type pending_q [$];
   int                     errors;
   int                     cycles;
   int                     idle_pct;
   bit                     calm;
   logic signed [DW-1:0]   ramp;

   // Rank 3 after reset; rank writes restart the stream.
   dir_row_type dir_rows [24] = '{
      '{ROW_SAMPLE, 32'sd100,  1'b1, 32'sd100},
      '{ROW_SAMPLE, S_MIN,     1'b1, S_MIN},
      '{ROW_SAMPLE, S_MAX,     1'b1, S_MIN},
      '{ROW_SAMPLE, S_MIN,     1'b1, S_MIN},
      '{ROW_SAMPLE, 32'sd50,   1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd50,   1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd0,    1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd200,  1'b0, 32'sd0},
      '{ROW_SAMPLE, -32'sd1,   1'b0, 32'sd0},
      '{ROW_SAMPLE, S_MAX,     1'b0, 32'sd0},
      '{ROW_RANK,   32'sd0,    1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd5,    1'b1, 32'sd5},
      '{ROW_SAMPLE, 32'sd3,    1'b1, 32'sd5},
      '{ROW_SAMPLE, 32'sd5,    1'b1, 32'sd5},
      '{ROW_SAMPLE, 32'sd9,    1'b1, 32'sd9},
      '{ROW_RANK,   32'sd31,   1'b0, 32'sd0},
      '{ROW_SAMPLE, -32'sd7,   1'b1, -32'sd7},
      '{ROW_SAMPLE, S_MAX,     1'b0, 32'sd0},
      '{ROW_SAMPLE, S_MIN,     1'b0, 32'sd0},
      '{ROW_RANK,   32'sd17,   1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd1,    1'b1, 32'sd1},
      '{ROW_RANK,   32'sd1,    1'b0, 32'sd0},
      '{ROW_SAMPLE, 32'sd42,   1'b1, 32'sd42},
      '{ROW_SAMPLE, S_MIN,     1'b1, 32'sd42}
   };

   streaming_kth_largest_tracker_core #(
      .MAX_RANK(STORE_DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_echo (rsp_sample_echo),
      .rsp_kth_largest (rsp_kth_largest)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      begin
         $display("ERROR @%0t: %s", $time, msg);
         errors++;
      end
   endtask

   // Update the kept set with one sample and return the new minimum.
   function automatic logic signed [DW-1:0] track_sample(input logic signed [DW-1:0] s);
      int k;
      int p;
      begin
         k = (rank_reg == '0) ? 1 : ((rank_reg > STORE_DEPTH) ? STORE_DEPTH : int'(rank_reg));
         if (kept_count < k) begin
            p = kept_count;
            while (p > 0 && kept_chain[p-1] > s) begin
               kept_chain[p] = kept_chain[p-1];
               p--;
            end
            kept_chain[p] = s;
            kept_count++;
         end else if (s > kept_chain[0]) begin
            p = 0;
            while (p + 1 < kept_count && kept_chain[p+1] < s) begin
               kept_chain[p] = kept_chain[p+1];
               p++;
            end
            kept_chain[p] = s;
         end
         return kept_chain[0];
      end
   endfunction

   function automatic logic signed [DW-1:0] pick_sample();
      logic signed [DW-1:0] v;
      begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            // narrow range: lots of ties with the minimum
            4, 5: v = $signed($urandom_range(0, 15)) - 8;
            6: begin
               case ($urandom_range(0, 3))
                  0: v = S_MIN;
                  1: v = S_MAX;
                  2: v = '0;
                  default: v = -1;
               endcase
            end
            7, 8: begin
               // rising run: once the chain is full, each new sample walks past the whole chain
               ramp = ramp + $signed($urandom_range(1, 5000));
               v = ramp;
            end
            default: begin
               ramp = ramp - $signed($urandom_range(1, 5000));
               v = ramp;
            end
         endcase
         return v;
      end
   endfunction

   task automatic send_sample(input logic signed [DW-1:0] s, input bit typed,
                              input logic signed [DW-1:0] typed_kth);
      int gap;
      kthtrk_pkg::result_type beat;
      logic signed [DW-1:0] kth;
      begin
         gap = (!calm && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
         @(negedge clock);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid  <= 1'b1;
         req_sample <= s;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         kth = track_sample(s);
         beat.sample_echo = s;
         beat.kth_largest = typed ? typed_kth : kth;
         pending_q.insert(pending_q.size(), beat);
      end
   endtask

   // Drain the block, then write the rank; the write also empties the store.
   task automatic write_rank(input logic [RW-1:0] r);
      begin
         @(negedge clock);
         req_valid <= 1'b0;
         while (pending_q.size() != 0) @(posedge clock);
         @(negedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= r;
         @(negedge clock);
         csr_wr_en <= 1'b0;
         rank_reg   = r;
         kept_count = 0;
      end
   endtask

   // Result side: random backpressure bursts.
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && !reset && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 4);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      kthtrk_pkg::result_type exp_beat;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected beat: echo %0d kth %0d",
                             rsp_sample_echo, rsp_kth_largest));
         end else begin
            exp_beat = pending_q.pop_front();
            if (rsp_sample_echo !== exp_beat.sample_echo)
               report($sformatf("sample_echo got %0d expected %0d",
                                rsp_sample_echo, exp_beat.sample_echo));
            if (rsp_kth_largest !== exp_beat.kth_largest)
               report($sformatf("kth_largest got %0d expected %0d (echo %0d)",
                                rsp_kth_largest, exp_beat.kth_largest, exp_beat.sample_echo));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_streaming_kth_largest_tracker_core failed");
         $finish;
      end
   end

   initial begin
      logic [RW-1:0] phase_ranks [8];
      errors      = 0;
      cycles      = 0;
      calm        = 1'b0;
      idle_pct    = 25;
      ramp        = '0;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_sample  = '0;
      rank_reg    = kthtrk_pkg::RANK_RESET;
      kept_count  = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_RANK)
            write_rank(dir_rows[i].value[RW-1:0]);
         else
            send_sample(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].kth);
      end

      phase_ranks = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'($urandom_range(2, 15)), 5'd20, 5'd16};
      foreach (phase_ranks[ph]) begin
         write_rank(phase_ranks[ph]);
         // some phases run without any idling; the last one is fully calm
         idle_pct = (ph == 2 || ph == 5) ? 0 : 30;
         calm     = (ph == 7);
         ramp     = $urandom;
         repeat (PHASE_ITEMS) send_sample(pick_sample(), 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb_streaming_kth_largest_tracker_core passed");
      else
         $display("tb_streaming_kth_largest_tracker_core failed");
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/kthtrk_pkg.sv
sv/kthtrk_store.sv
sv/kthtrk_seq.sv
sv/streaming_kth_largest_tracker_core.sv
sv/kthtrk_checker.sv
tb/tb_streaming_kth_largest_tracker_core.sv
